// File: rtl/core/itp_pkg.sv
// Shared types and constants for the integer text parser.
package itp_pkg;

    localparam int CH_W       = 8;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

    // Configuration reset values
    localparam logic [BASE_W-1:0] NUMBER_BASE_RST = 6'd10;
    localparam logic              SIGNED_MODE_RST = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd2;

    // Radix values
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    // Character codes
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_DIG_0   = 8'h30;
    localparam logic [CH_W-1:0] CH_DIG_9   = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CH_W-1:0] ALPHA_OFS  = 8'd10;

    // Parse phase of the current string
    typedef enum logic [1:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // Classification of one character byte
    typedef struct packed {
        logic                is_space;
        logic                is_plus;
        logic                is_minus;
        logic                is_zero;
        logic                is_lower_x;
        logic                is_alnum;
        logic [DIGIT_W-1:0]  digit;
    } char_class_t;

endpackage

// File: rtl/core/itp_char_decode.sv
// Character classifier: whitespace, sign, prefix characters and digit value.
module itp_char_decode (
    input  logic [itp_pkg::CH_W-1:0] ch,
    output itp_pkg::char_class_t     cls
);
    import itp_pkg::*;

    logic [CH_W-1:0] dig_val;
    logic            is_num;
    logic            is_low;
    logic            is_up;

    // Range tests for the three digit groups
    assign is_num = (ch >= CH_DIG_0)   && (ch <= CH_DIG_9);
    assign is_low = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    assign is_up  = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);

    // Digit value, 0..35
    always_comb
    begin
        if (is_num)
        begin
            dig_val = ch - CH_DIG_0;
        end
        else if (is_low)
        begin
            dig_val = ch - CH_LOWER_A + ALPHA_OFS;
        end
        else
        begin
            dig_val = ch - CH_UPPER_A + ALPHA_OFS;
        end
    end

    assign cls.is_space   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign cls.is_plus    = (ch == CH_PLUS);
    assign cls.is_minus   = (ch == CH_MINUS);
    assign cls.is_zero    = (ch == CH_DIG_0);
    assign cls.is_lower_x = (ch == CH_LOWER_X);
    assign cls.is_alnum   = is_num || is_low || is_up;
    assign cls.digit      = dig_val[DIGIT_W-1:0];

endmodule

// File: rtl/core/itp_step.sv
// One parse step: next parser state and the result item for one character.
module itp_step #(
    parameter int VALUE_BITS = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic                        first,
    input  itp_pkg::char_class_t        cls,
    input  logic [itp_pkg::BASE_W-1:0]  number_base,
    input  logic                        signed_mode,
    input  itp_pkg::phase_t             phase,
    input  logic                        is_negative,
    input  logic [VALUE_BITS-1:0]       accumulator,
    input  logic [itp_pkg::BASE_W-1:0]  active_base,
    input  logic [INDEX_BITS-1:0]       char_index,
    input  logic                        finished,
    output itp_pkg::phase_t             phase_next,
    output logic                        is_negative_next,
    output logic [VALUE_BITS-1:0]       accumulator_next,
    output logic [itp_pkg::BASE_W-1:0]  active_base_next,
    output logic [INDEX_BITS-1:0]       char_index_next,
    output logic                        finished_next,
    output logic                        emit,
    output logic [VALUE_BITS-1:0]       res_value,
    output logic [itp_pkg::STATUS_W-1:0] res_status,
    output logic [INDEX_BITS-1:0]       res_end
);
    import itp_pkg::*;

    localparam int PROD_W = VALUE_BITS + BASE_W;
    localparam int SUM_W  = VALUE_BITS + BASE_W + 1;

    localparam logic [VALUE_BITS-1:0] ALL_ONES   = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] SIGNED_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] SIGNED_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    phase_t                ph;
    logic                  neg;
    logic [VALUE_BITS-1:0] acc;
    logic [BASE_W-1:0]     base;
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] idx_inc;
    logic                  live;
    logic                  bad_base;
    logic                  take_sign;
    logic                  reach_prefix;
    logic                  take_zero;
    logic                  take_x;
    logic [BASE_W-1:0]     base_pre;
    logic [BASE_W-1:0]     base_eff;
    logic                  digit_ok;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      sum;
    logic [VALUE_BITS-1:0] limit;
    logic                  overflow;

    // Start of a string replaces the carried state
    assign ph   = first ? PH_SPACE : phase;
    assign neg  = first ? 1'b0 : is_negative;
    assign acc  = first ? '0 : accumulator;
    assign base = first ? number_base : active_base;
    assign idx  = first ? '0 : char_index;
    assign idx_inc = idx + INDEX_BITS'(1);

    assign live     = first || !finished;
    assign bad_base = first && (base != BASE_AUTO) && ((base < BASE_MIN) || (base > BASE_MAX));

    // Phase fall-through: whitespace -> sign -> prefix -> digits
    assign take_sign    = (ph == PH_SPACE) && !cls.is_space && signed_mode
                          && (cls.is_plus || cls.is_minus);
    assign reach_prefix = ((ph == PH_SPACE) && !cls.is_space && !take_sign)
                          || (ph == PH_PREFIX);
    assign take_zero    = reach_prefix && (base == BASE_AUTO) && cls.is_zero;
    assign take_x       = (ph == PH_ZERO) && cls.is_lower_x;
    assign base_pre     = (reach_prefix && (base == BASE_AUTO)) ? BASE_DEC : base;
    assign base_eff     = ((base_pre < BASE_MIN) || (base_pre > BASE_MAX)) ? BASE_DEC : base_pre;
    assign digit_ok     = cls.is_alnum && (cls.digit < base_eff);

    // Accumulate and range check: acc*base + digit > limit
    assign prod     = PROD_W'(acc) * PROD_W'(base_eff);
    assign sum      = SUM_W'(prod) + SUM_W'(cls.digit);
    assign limit    = signed_mode ? SIGNED_MAX : ALL_ONES;
    assign overflow = sum > SUM_W'(limit);

    always_comb
    begin
        phase_next       = ph;
        is_negative_next = neg;
        accumulator_next = acc;
        active_base_next = base;
        char_index_next  = idx;
        finished_next    = first ? 1'b0 : finished;
        emit             = 1'b0;
        res_value        = '0;
        res_status       = ST_OK;
        res_end          = idx;

        if (!live)
        begin
            finished_next = finished;
        end
        else if (bad_base)
        begin
            emit          = 1'b1;
            finished_next = 1'b1;
            res_status    = ST_BAD_BASE;
            res_end       = '0;
        end
        else if ((ph == PH_SPACE) && cls.is_space)
        begin
            char_index_next = idx_inc;
        end
        else if (take_sign)
        begin
            is_negative_next = cls.is_minus;
            phase_next       = PH_PREFIX;
            char_index_next  = idx_inc;
        end
        else if (take_zero)
        begin
            active_base_next = BASE_OCT;
            phase_next       = PH_ZERO;
            char_index_next  = idx_inc;
        end
        else if (take_x)
        begin
            active_base_next = BASE_HEX;
            phase_next       = PH_DIGITS;
            char_index_next  = idx_inc;
        end
        else
        begin
            phase_next       = PH_DIGITS;
            active_base_next = base_pre;
            if (!digit_ok)
            begin
                // End of digits: deliver the value
                emit          = 1'b1;
                finished_next = 1'b1;
                res_value     = neg ? (VALUE_BITS'(0) - acc) : acc;
            end
            else if (overflow)
            begin
                // Saturate
                emit          = 1'b1;
                finished_next = 1'b1;
                res_status    = ST_RANGE;
                if (!signed_mode)
                begin
                    res_value = ALL_ONES;
                end
                else
                begin
                    res_value = neg ? SIGNED_MIN : SIGNED_MAX;
                end
            end
            else
            begin
                accumulator_next = sum[VALUE_BITS-1:0];
                char_index_next  = idx_inc;
            end
        end
    end

endmodule

// File: rtl/core/integer_text_parser.sv
// Streaming string-to-integer parser in the manner of strtol/strtoul.
//
// Usage:
//   Character items arrive on char_valid/char_ready with ch and first; first
//   starts a new string at index 0 and abandons any string in progress.
//   Each completed string gives one result item on res_valid/res_ready: value_bits,
//   status (ok, out of range, invalid base) and end_index.
//   number_base and signed_mode are written through cfg_wr_en/cfg_index/
//   cfg_data while the block is idle; the base is latched at string start.
// Pipeline and throughput:
//   A character is taken into an input register; the parse step runs from
//   that register and loads the result register when the result register
//   is free or being drained. One character per cycle is sustained while no
//   result waits for res_ready; the step is one 64x6 multiply, an add and a compare.
// Reset:
//   Clears the configuration to base 10 and signed mode, empties both
//   registers and leaves the parser waiting for a first character.
// Stall:
//   While a result waits for res_ready, the input register holds its
//   character and char_ready drops once it is full; characters that give no
//   result still pass only when the result register can take a new one.
module integer_text_parser #(
    parameter int VALUE_BITS = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [itp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [itp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             char_valid,
    output logic                             char_ready,
    input  logic [itp_pkg::CH_W-1:0]         ch,
    input  logic                             first,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [VALUE_BITS-1:0]            value_bits,
    output logic [itp_pkg::STATUS_W-1:0]     status,
    output logic [INDEX_BITS-1:0]            end_index
);
    import itp_pkg::*;

    // Configuration
    logic [BASE_W-1:0]     number_base_reg;
    logic                  signed_mode_reg;

    // Input register
    logic                  s1_valid_reg;
    logic [CH_W-1:0]       s1_ch_reg;
    logic                  s1_first_reg;
    logic                  s1_fire;

    // Parser state
    phase_t                phase_reg;
    logic                  is_negative_reg;
    logic [VALUE_BITS-1:0] accumulator_reg;
    logic [BASE_W-1:0]     active_base_reg;
    logic [INDEX_BITS-1:0] char_index_reg;
    logic                  finished_reg;

    phase_t                phase_next;
    logic                  is_negative_next;
    logic [VALUE_BITS-1:0] accumulator_next;
    logic [BASE_W-1:0]     active_base_next;
    logic [INDEX_BITS-1:0] char_index_next;
    logic                  finished_next;

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [INDEX_BITS-1:0] end_index_reg;

    char_class_t           cls;
    logic                  step_emit;
    logic [VALUE_BITS-1:0] step_value;
    logic [STATUS_W-1:0]   step_status;
    logic [INDEX_BITS-1:0] step_end;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= NUMBER_BASE_RST;
            signed_mode_reg <= SIGNED_MODE_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_NUMBER_BASE)
            begin
                number_base_reg <= cfg_data[BASE_W-1:0];
            end
            else
            begin
                signed_mode_reg <= cfg_data[0];
            end
        end
    end

    // Handshake: step runs when the result register is free or being drained
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || res_ready);
    assign char_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            s1_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            s1_ch_reg    <= ch;
            s1_first_reg <= first;
        end
    end

    itp_char_decode u_decode (
        .ch  (s1_ch_reg),
        .cls (cls)
    );

    itp_step #(
        .VALUE_BITS (VALUE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .first            (s1_first_reg),
        .cls              (cls),
        .number_base      (number_base_reg),
        .signed_mode      (signed_mode_reg),
        .phase            (phase_reg),
        .is_negative      (is_negative_reg),
        .accumulator      (accumulator_reg),
        .active_base      (active_base_reg),
        .char_index       (char_index_reg),
        .finished         (finished_reg),
        .phase_next       (phase_next),
        .is_negative_next (is_negative_next),
        .accumulator_next (accumulator_next),
        .active_base_next (active_base_next),
        .char_index_next  (char_index_next),
        .finished_next    (finished_next),
        .emit             (step_emit),
        .res_value        (step_value),
        .res_status       (step_status),
        .res_end          (step_end)
    );

    // Parser state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SPACE;
            is_negative_reg <= 1'b0;
            accumulator_reg <= '0;
            active_base_reg <= BASE_AUTO;
            char_index_reg  <= '0;
            finished_reg    <= 1'b1;
        end
        else if (s1_fire)
        begin
            phase_reg       <= phase_next;
            is_negative_reg <= is_negative_next;
            accumulator_reg <= accumulator_next;
            active_base_reg <= active_base_next;
            char_index_reg  <= char_index_next;
            finished_reg    <= finished_next;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !res_ready;
        if (s1_fire && step_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && step_emit)
        begin
            value_reg     <= step_value;
            status_reg    <= step_status;
            end_index_reg <= step_end;
        end
    end

    assign res_valid  = out_valid_reg;
    assign value_bits = value_reg;
    assign status     = status_reg;
    assign end_index  = end_index_reg;

    // Checks
    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_BAD_BASE) |-> (value_reg == '0) && (end_index_reg == '0))
        else $error("invalid-base result carries nonzero value or index");

    a_emit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && step_emit |=> finished_reg && out_valid_reg)
        else $error("result issued without finishing the string");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_ch_reg) && $stable(s1_first_reg))
        else $error("stalled character lost from input register");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |=> out_valid_reg && $stable(value_reg) && $stable(status_reg))
        else $error("stalled result changed");

endmodule

// File: tb/sv/integer_text_parser_tb.sv
// Self-checking testbench for the integer text parser: directed and random strings.
module integer_text_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int VALUE_W     = 64;
    localparam int INDEX_W     = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 8;
    localparam int NO_DIGIT    = 99;

    // Whitespace codes and the terminator not named in the package
    localparam logic [CH_W-1:0] CH_NUL = 8'h00;
    localparam logic [CH_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF  = 8'h0C;

    localparam logic [VALUE_W-1:0] U64_MAX = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] S64_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] S64_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
    } char_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_bits;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  end_index;
    } number_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   char_valid = 1'b0;
    logic                   char_ready;
    logic [CH_W-1:0]        ch = '0;
    logic                   first = 1'b0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [VALUE_W-1:0]     value_bits;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_W-1:0]     end_index;

    // Characters waiting to be sent and numbers waiting to come out
    char_item_t  char_stream[$];
    number_t     parsed_numbers[$];
    char_item_t  upcoming;
    number_t     want;

    int unsigned chars_queued = 0;
    int unsigned chars_taken = 0;
    int unsigned numbers_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned bad_base_seen = 0;
    int unsigned settings_used = 0;
    int unsigned bad_fields = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    // Register settings for the random phases
    int unsigned phase_base [12] = '{10, 0, 0, 2, 36, 16, 8, 36, 2, 1, 63, 37};
    bit          phase_signed [12] = '{1, 1, 0, 1, 0, 0, 1, 1, 0, 1, 0, 1};

    // Register copies and parser state for prediction
    logic [BASE_W-1:0]  base_reg = NUMBER_BASE_RST;
    logic               signed_reg = SIGNED_MODE_RST;
    phase_t             prs_phase = PH_SPACE;
    logic               prs_negative = 1'b0;
    logic [VALUE_W-1:0] prs_acc = '0;
    logic [BASE_W-1:0]  prs_radix = '0;
    logic [INDEX_W-1:0] prs_index = '0;
    logic               prs_done = 1'b1;

    integer_text_parser #(
        .VALUE_BITS(VALUE_W),
        .INDEX_BITS(INDEX_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .ch         (ch),
        .first      (first),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .value_bits (value_bits),
        .status     (status),
        .end_index  (end_index)
    );

    always #6 clk = ~clk;

    function automatic int unsigned digit_value(logic [CH_W-1:0] c);
        if (c >= CH_DIG_0 && c <= CH_DIG_9)
            return int'(c - CH_DIG_0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return int'(c - CH_LOWER_A) + int'(ALPHA_OFS);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return int'(c - CH_UPPER_A) + int'(ALPHA_OFS);
        return NO_DIGIT;
    endfunction

    function automatic logic [CH_W-1:0] digit_char(int unsigned v);
        if (v < 10)
            return CH_DIG_0 + CH_W'(v);
        if ($urandom_range(0, 1) != 0)
            return CH_LOWER_A + CH_W'(v) - ALPHA_OFS;
        return CH_UPPER_A + CH_W'(v) - ALPHA_OFS;
    endfunction

    function automatic logic [CH_W-1:0] space_char(int unsigned k);
        case (k)
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void emit_number(logic [VALUE_W-1:0] v, logic [STATUS_W-1:0] s);
        number_t n;
        n.value_bits = v;
        n.status = s;
        n.end_index = prs_index;
        parsed_numbers.push_back(n);
        prs_done = 1'b1;
    endfunction

    // One parse step per accepted character; pushes a number when the string ends
    function automatic void parse_char(logic [CH_W-1:0] c, logic f);
        logic [71:0]        grown;
        logic [VALUE_W-1:0] limit;
        int unsigned        d;
        bit                 stop;
        if (f) begin
            prs_phase = PH_SPACE;
            prs_negative = 1'b0;
            prs_acc = '0;
            prs_index = '0;
            prs_done = 1'b0;
            prs_radix = base_reg;
            if (prs_radix != BASE_AUTO && (prs_radix < BASE_MIN || prs_radix > BASE_MAX)) begin
                emit_number('0, ST_BAD_BASE);
                return;
            end
        end
        else if (prs_done) begin
            return;
        end
        stop = 1'b0;
        while (!stop) begin
            case (prs_phase)
                PH_SPACE: begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                        prs_index = prs_index + 1'b1;
                        stop = 1'b1;
                    end
                    else begin
                        prs_phase = PH_PREFIX;
                        if (signed_reg && (c == CH_PLUS || c == CH_MINUS)) begin
                            prs_negative = (c == CH_MINUS);
                            prs_index = prs_index + 1'b1;
                            stop = 1'b1;
                        end
                    end
                end
                PH_PREFIX: begin
                    if (prs_radix == BASE_AUTO) begin
                        if (c == CH_DIG_0) begin
                            prs_radix = BASE_OCT;
                            prs_phase = PH_ZERO;
                            prs_index = prs_index + 1'b1;
                            stop = 1'b1;
                        end
                        else begin
                            prs_radix = BASE_DEC;
                        end
                    end
                    if (!stop)
                        prs_phase = PH_DIGITS;
                end
                PH_ZERO: begin
                    prs_phase = PH_DIGITS;
                    if (c == CH_LOWER_X) begin
                        prs_radix = BASE_HEX;
                        prs_index = prs_index + 1'b1;
                        stop = 1'b1;
                    end
                end
                default: begin
                    d = digit_value(c);
                    limit = signed_reg ? S64_MAX : U64_MAX;
                    grown = 72'(prs_acc) * 72'(prs_radix) + 72'(d);
                    if (d >= prs_radix)
                        emit_number(prs_negative ? -prs_acc : prs_acc, ST_OK);
                    else if (grown > 72'(limit))
                        emit_number(!signed_reg ? U64_MAX :
                                    (prs_negative ? S64_MIN : S64_MAX), ST_RANGE);
                    else begin
                        prs_acc = grown[VALUE_W-1:0];
                        prs_index = prs_index + 1'b1;
                    end
                    stop = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void send_char(logic [CH_W-1:0] c, logic f);
        char_item_t it;
        it.ch = c;
        it.first = f;
        char_stream.push_back(it);
        chars_queued++;
    endfunction

    function automatic void send_text(string s, bit starts);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], starts && i == 0);
    endfunction

    // Random string: whitespace, sign, prefix, digits, stop byte, trailing bytes.
    // Returns the number of characters sent, not counting the trailing bytes.
    function automatic int unsigned add_random_string();
        logic [CH_W-1:0] text[$];
        logic [79:0]     span;
        int unsigned     radix;
        int unsigned     fit;
        int unsigned     len;
        int unsigned     used;
        logic [CH_W-1:0] c;
        // plain noise now and then
        if ($urandom_range(0, 19) == 0) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_char(CH_W'($urandom_range(0, 255)), i == 0);
            return len;
        end
        if ($urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, 3)) text.push_back(space_char($urandom_range(0, 5)));
        if ($urandom_range(0, 2) == 0)
            text.push_back(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
        radix = base_reg;
        if (radix == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    text.push_back(CH_DIG_0);
                    text.push_back(CH_LOWER_X);
                    radix = BASE_HEX;
                end
                1: begin
                    text.push_back(CH_DIG_0);
                    radix = BASE_OCT;
                end
                default: radix = BASE_DEC;
            endcase
        end
        else if (radix < BASE_MIN || radix > BASE_MAX) begin
            radix = BASE_MAX;
        end
        // digits that just reach past 64 bits in this radix
        span = 80'd1;
        fit = 0;
        while (span <= 80'(U64_MAX)) begin
            span = span * 80'(radix);
            fit++;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(0, 6);
            6, 7, 8:          len = $urandom_range(fit - 1, fit + 1);
            default:          len = $urandom_range(fit, fit + 6);
        endcase
        repeat (len) text.push_back(digit_char($urandom_range(0, radix - 1)));
        // stop byte, left off now and then so the next string restarts
        if ($urandom_range(0, 19) != 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: text.push_back(CH_NUL);
                4, 5, 6: begin
                    do c = CH_W'($urandom_range(0, 255));
                    while (digit_value(c) != NO_DIGIT);
                    text.push_back(c);
                end
                7, 8: begin
                    if (radix < BASE_MAX)
                        text.push_back(digit_char($urandom_range(radix, BASE_MAX - 1)));
                    else
                        text.push_back(CH_NUL);
                end
                default: text.push_back(CH_W'($urandom_range(0, 255)));
            endcase
        end
        used = text.size();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) text.push_back(CH_W'($urandom_range(0, 255)));
        foreach (text[i])
            send_char(text[i], i == 0);
        return used;
    endfunction

    task automatic wait_idle();
        while (chars_taken != chars_queued || parsed_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        if (idx == REG_NUMBER_BASE)
            base_reg = BASE_W'(val);
        else
            signed_reg = val[0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(int unsigned radix, bit sgn);
        wait_idle();
        write_reg(REG_NUMBER_BASE, radix);
        write_reg(REG_SIGNED_MODE, sgn);
        settings_used++;
    endtask

    // Character driver
    always @(posedge clk) begin
        if (!rst_n) begin
            char_valid <= 1'b0;
        end
        else begin
            if (char_valid && char_ready) begin
                parse_char(ch, first);
                chars_taken++;
            end
            if (!char_valid || char_ready) begin
                if (char_stream.size() != 0 && (steady || $urandom_range(0, 99) >= 8)) begin
                    upcoming = char_stream.pop_front();
                    char_valid <= 1'b1;
                    ch <= upcoming.ch;
                    first <= upcoming.first;
                end
                else begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end
        else begin
            if (res_valid && res_ready) begin
                if (parsed_numbers.size() == 0) begin
                    $error("result with nothing pending: value_bits %h status %0d end_index %0d",
                           value_bits, status, end_index);
                    bad_fields++;
                end
                else begin
                    want = parsed_numbers.pop_front();
                    if (value_bits !== want.value_bits) begin
                        $error("value_bits: expected %h, got %h", want.value_bits, value_bits);
                        bad_fields++;
                    end
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        bad_fields++;
                    end
                    if (end_index !== want.end_index) begin
                        $error("end_index: expected %0d, got %0d", want.end_index, end_index);
                        bad_fields++;
                    end
                    if (want.status == ST_RANGE)
                        saturated_seen++;
                    if (want.status == ST_BAD_BASE)
                        bad_base_seen++;
                    numbers_checked++;
                end
            end
            res_ready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("integer_text_parser test failed");
            $finish;
        end
    end

    initial begin
        int unsigned radix;
        bit          sgn;
        int unsigned budget;
        int unsigned sent;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // Reset settings: whitespace, sign, a 0xFF stop byte
        send_char(CH_TAB, 1'b1);
        send_char(CH_CR, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_text("-42", 1'b0);
        send_char(8'hFF, 1'b0);
        // restart abandons "+7"; the byte after the result is ignored
        send_text("+7", 1'b1);
        send_text("5", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_text("9", 1'b0);
        // signed mode drops mid-string: '-' then ends it, still negated
        send_text("-3", 1'b1);
        wait_idle();
        write_reg(REG_SIGNED_MODE, 0);
        send_text("9-", 1'b0);
        // a sign in unsigned mode is a stop byte
        send_text("+8", 1'b1);

        // Auto base: hex, octal, and "0x" with no hex digit after it
        configure(BASE_AUTO, 1'b1);
        send_text("0x1f", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_text("017", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_text("0xg", 1'b1);

        // Bases out of range
        configure(1, 1'b0);
        send_text("7", 1'b1);
        configure(63, 1'b1);
        send_text("z", 1'b1);

        // Unsigned saturation in base 36
        configure(BASE_MAX, 1'b0);
        send_text("ZZZZZZZZZZZZZ", 1'b1);

        // Random strings under a series of settings
        for (int p = 0; p < 14; p++) begin
            if (p < 12) begin
                radix = phase_base[p];
                sgn = phase_signed[p];
            end
            else begin
                radix = $urandom_range(BASE_MIN, BASE_MAX);
                sgn = $urandom_range(0, 1);
            end
            configure(radix, sgn);
            steady = (p == 4);
            budget = (radix != BASE_AUTO && (radix < BASE_MIN || radix > BASE_MAX)) ? 15 : 64;
            sent = 0;
            while (sent < budget)
                sent += add_random_string();
        end

        wait_idle();
        $display("%0d characters over %0d register settings, %0d numbers checked",
                 chars_taken, settings_used, numbers_checked);
        $display("%0d saturated, %0d with a bad base",
                 saturated_seen, bad_base_seen);
        if (bad_fields == 0)
            $display("integer_text_parser test passed");
        else
            $display("integer_text_parser test failed");
        $finish;
    end

endmodule

// File: integer_text_parser.f
rtl/core/itp_pkg.sv
rtl/core/itp_char_decode.sv
rtl/core/itp_step.sv
rtl/core/integer_text_parser.sv
tb/sv/integer_text_parser_tb.sv
